### rtl/dhcp_option_tlv_scanner_core_defines.svh
// ---------------------------------------------------------------------------
// DHCP option scanner: assertion macros
// Shared property macros for the scanner RTL. They expect clk and rst_n in
// the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef DHCP_OPTION_TLV_SCANNER_CORE_DEFINES_SVH
`define DHCP_OPTION_TLV_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DOTS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DOTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dots_pkg.sv
// ---------------------------------------------------------------------------
// DHCP option scanner package
// Widths, option codes, area sizes, codes and shared types.
// ---------------------------------------------------------------------------
package dots_pkg;

  localparam int BYTE_W     = 8;
  localparam int OPT_LEN_W  = 11;
  localparam int OFF_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int AREA_W     = 2;
  localparam int OVL_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [OPT_LEN_W-1:0] OPTIONS_LENGTH_RESET = 11'd312;
  localparam logic [OPT_LEN_W-1:0] MIN_OPTIONS_BYTES    = 11'd4;
  localparam logic [OPT_LEN_W-1:0] MAX_OPTIONS_BYTES    = 11'd1024;
  localparam logic [OPT_LEN_W-1:0] FILE_AREA_BYTES      = 11'd128;
  localparam logic [OPT_LEN_W-1:0] NAME_AREA_BYTES      = 11'd64;

  localparam logic [BYTE_W-1:0] SEARCH_CODE_RESET = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_PAD           = 8'd0;
  localparam logic [BYTE_W-1:0] OPT_END           = 8'd255;
  localparam logic [BYTE_W-1:0] OPT_OVERLOAD      = 8'd52;

  localparam logic [OFF_W-1:0] COOKIE_LAST_OFF = 10'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_CODE    = 4'd0,
    CFG_OPTIONS_LENGTH = 4'd1
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_COOKIE = 2'd2
  } status_t;

  typedef enum logic [AREA_W-1:0] {
    AREA_OPT  = 2'd0,
    AREA_FILE = 2'd1,
    AREA_NAME = 2'd2
  } area_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COOKIE   = 3'd1,
    PH_CODE     = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_VALUE    = 3'd4,
    PH_OVERLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              packet_start;
  } item_t;

  typedef struct packed {
    status_t           status;
    area_t             area;
    logic [OFF_W-1:0]  value_offset;
    logic [BYTE_W-1:0] value_length;
    logic [OVL_W-1:0]  overload_seen;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    search_code;
    logic [OPT_LEN_W-1:0] options_length;
  } cfg_t;

  // Magic cookie 99, 130, 83, 99.
  function automatic logic [BYTE_W-1:0] cookie_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] v;
    case (idx)
      2'd0:    v = 8'd99;
      2'd1:    v = 8'd130;
      2'd2:    v = 8'd83;
      default: v = 8'd99;
    endcase
    return v;
  endfunction

endpackage

### rtl/dots_byte_if.sv
// ---------------------------------------------------------------------------
// DHCP option scanner byte channel
// Valid/ready channel carrying one packet byte and the packet start flag.
// ---------------------------------------------------------------------------
interface dots_byte_if;
  import dots_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              packet_start;

  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

### rtl/dots_result_if.sv
// ---------------------------------------------------------------------------
// DHCP option scanner result channel
// Valid/ready channel carrying one lookup result per packet.
// ---------------------------------------------------------------------------
interface dots_result_if;
  import dots_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [AREA_W-1:0]   area;
  logic [OFF_W-1:0]    value_offset;
  logic [BYTE_W-1:0]   value_length;
  logic [OVL_W-1:0]    overload_seen;

  modport source (output valid, output status, output area, output value_offset,
                  output value_length, output overload_seen, input ready);
  modport sink (input valid, input status, input area, input value_offset,
                input value_length, input overload_seen, output ready);
endinterface

### rtl/dots_cfg_if.sv
// ---------------------------------------------------------------------------
// DHCP option scanner configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface dots_cfg_if;
  import dots_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/dots_cfg_regs.sv
// ---------------------------------------------------------------------------
// DHCP option scanner configuration registers
// Decodes register writes into the search code and options length.
// ---------------------------------------------------------------------------
module dots_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  dots_cfg_if.sink      cfg_bus,
  output dots_pkg::cfg_t cfg
);
  import dots_pkg::*;

  logic [BYTE_W-1:0]    search_code_r;
  logic [BYTE_W-1:0]    search_code_nxt;
  logic [OPT_LEN_W-1:0] options_length_r;
  logic [OPT_LEN_W-1:0] options_length_nxt;
  logic                 wr_en;

  assign cfg_bus.ready = 1'b1;
  assign wr_en         = cfg_bus.valid;

  always_comb begin
    search_code_nxt    = search_code_r;
    options_length_nxt = options_length_r;
    if (wr_en) begin
      case (cfg_bus.reg_index)
        CFG_SEARCH_CODE:    search_code_nxt    = cfg_bus.wdata[BYTE_W-1:0];
        CFG_OPTIONS_LENGTH: options_length_nxt = cfg_bus.wdata[OPT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_code_r    <= SEARCH_CODE_RESET;
      options_length_r <= OPTIONS_LENGTH_RESET;
    end else begin
      search_code_r    <= search_code_nxt;
      options_length_r <= options_length_nxt;
    end
  end

  assign cfg.search_code    = search_code_r;
  assign cfg.options_length = options_length_r;
endmodule

### rtl/dots_in_stage.sv
// ---------------------------------------------------------------------------
// DHCP option scanner input register
// Registers each accepted byte word and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module dots_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  dots_byte_if.sink       in_bus,
  input  logic            item_take,
  output logic            item_vld,
  output dots_pkg::item_t item
);
  import dots_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_bus.ready = !valid_r || item_take;
  assign accept       = in_bus.valid && in_bus.ready;
  assign valid_nxt    = accept || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte    <= in_bus.data_byte;
      item_r.packet_start <= in_bus.packet_start;
    end
  end

  assign item_vld = valid_r;
  assign item     = item_r;
endmodule

### rtl/dots_parse.sv
// ---------------------------------------------------------------------------
// DHCP option scanner parse engine
// Per-byte option walk: cookie check, code/length/value tracking, overload
// capture, area sequencing and result decision, one byte per cycle when out_free is high.
// ---------------------------------------------------------------------------
`include "dhcp_option_tlv_scanner_core_defines.svh"

module dots_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  dots_pkg::cfg_t    cfg,
  input  logic              item_vld,
  input  dots_pkg::item_t   item,
  input  logic              out_free,
  output logic              item_take,
  output logic              res_vld,
  output dots_pkg::result_t res
);
  import dots_pkg::*;

  phase_t               phase_r, phase_nxt;
  area_t                area_r, area_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [BYTE_W-1:0]    skip_r, skip_nxt;
  logic [BYTE_W-1:0]    code_r, code_nxt;
  logic [OVL_W-1:0]     ovl_r, ovl_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 done_r, done_nxt;
  logic [OPT_LEN_W-1:0] held_r, held_nxt;

  // State as seen by the current byte, after a packet start restart.
  phase_t               e_phase;
  area_t                e_area;
  logic [OFF_W-1:0]     e_off;
  logic [BYTE_W-1:0]    e_skip;
  logic [BYTE_W-1:0]    e_code;
  logic [OVL_W-1:0]     e_ovl;
  logic                 e_stopped;
  logic                 e_done;
  logic [OPT_LEN_W-1:0] e_held;
  logic [OPT_LEN_W-1:0] clamp_len;

  logic [BYTE_W-1:0]    b;
  logic [OPT_LEN_W-1:0] sz;
  logic [OPT_LEN_W-1:0] off_ext;
  logic [OPT_LEN_W-1:0] off_inc;
  logic [OPT_LEN_W-1:0] rem;
  logic                 last;
  logic                 area_en;
  logic                 active;
  logic [BYTE_W-1:0]    skip_dec;

  logic                 cookie_bad;
  logic                 len_over;
  logic                 found;
  logic                 code_stop;
  logic [OVL_W-1:0]     ovl_upd;
  logic                 later_en;
  logic                 not_found;
  logic                 res_any;

  assign b         = item.data_byte;
  assign item_take = item_vld && out_free;
  assign res_vld   = item_take && res_any;

  always_comb begin
    if (cfg.options_length < MIN_OPTIONS_BYTES) begin
      clamp_len = MIN_OPTIONS_BYTES;
    end else if (cfg.options_length > MAX_OPTIONS_BYTES) begin
      clamp_len = MAX_OPTIONS_BYTES;
    end else begin
      clamp_len = cfg.options_length;
    end
  end

  always_comb begin
    if (item.packet_start) begin
      e_phase   = PH_COOKIE;
      e_area    = AREA_OPT;
      e_off     = '0;
      e_skip    = '0;
      e_code    = '0;
      e_ovl     = '0;
      e_stopped = 1'b0;
      e_done    = 1'b0;
      e_held    = clamp_len;
    end else begin
      e_phase   = phase_r;
      e_area    = area_r;
      e_off     = off_r;
      e_skip    = skip_r;
      e_code    = code_r;
      e_ovl     = ovl_r;
      e_stopped = stopped_r;
      e_done    = done_r;
      e_held    = held_r;
    end
  end

  always_comb begin
    case (e_area)
      AREA_OPT: begin
        sz      = e_held;
        area_en = 1'b1;
      end
      AREA_FILE: begin
        sz      = FILE_AREA_BYTES;
        area_en = e_ovl[0];
      end
      default: begin
        sz      = NAME_AREA_BYTES;
        area_en = e_ovl[1];
      end
    endcase
  end

  assign off_ext  = {1'b0, e_off};
  assign off_inc  = off_ext + 11'd1;
  assign last     = (off_inc >= sz);
  assign rem      = sz - off_inc;
  assign active   = !e_done && !e_stopped && area_en;
  assign skip_dec = e_skip - 8'd1;

  // Events decided by this byte.
  always_comb begin
    cookie_bad = active && (e_phase == PH_COOKIE) && (b != cookie_byte(e_off[1:0]));
    len_over   = active && (e_phase == PH_LENGTH) && ({3'b000, b} > rem);
    found      = active && (e_phase == PH_LENGTH) && !len_over && (e_code == cfg.search_code);
    code_stop  = active && (e_phase == PH_CODE) &&
                 ((b == OPT_END) || ((b != OPT_PAD) && last));
    if (cookie_bad) begin
      ovl_upd = '0;
    end else if (active && (e_phase == PH_OVERLOAD)) begin
      ovl_upd = b[OVL_W-1:0];
    end else begin
      ovl_upd = e_ovl;
    end
    case (e_area)
      AREA_OPT:  later_en = (ovl_upd != 2'b00);
      AREA_FILE: later_en = ovl_upd[1];
      default:   later_en = 1'b0;
    endcase
    not_found = !e_done && !cookie_bad && !found &&
                (e_stopped || code_stop || len_over || last) && !later_en;
    res_any   = cookie_bad || found || not_found;
  end

  // Next state.
  always_comb begin
    phase_nxt   = e_phase;
    area_nxt    = e_area;
    off_nxt     = e_off;
    skip_nxt    = e_skip;
    code_nxt    = e_code;
    ovl_nxt     = ovl_upd;
    stopped_nxt = e_stopped;
    done_nxt    = e_done;
    held_nxt    = e_held;
    if (!e_done) begin
      if (res_any) begin
        done_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        if (active) begin
          case (e_phase)
            PH_COOKIE: begin
              if (e_off >= COOKIE_LAST_OFF) begin
                phase_nxt = PH_CODE;
              end
            end
            PH_CODE: begin
              if (code_stop) begin
                stopped_nxt = 1'b1;
              end else if (b != OPT_PAD) begin
                code_nxt  = b;
                phase_nxt = PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              if (len_over) begin
                stopped_nxt = 1'b1;
              end else begin
                skip_nxt = b;
                if (b == OPT_PAD) begin
                  phase_nxt = PH_CODE;
                end else if ((e_code == OPT_OVERLOAD) && (e_area == AREA_OPT)) begin
                  phase_nxt = PH_OVERLOAD;
                end else begin
                  phase_nxt = PH_VALUE;
                end
              end
            end
            PH_OVERLOAD, PH_VALUE: begin
              skip_nxt  = skip_dec;
              phase_nxt = (skip_dec != 8'd0) ? PH_VALUE : PH_CODE;
            end
            default: begin
              phase_nxt = PH_CODE;
            end
          endcase
        end
        // The last byte of an area hands over to the next one.
        if (last) begin
          phase_nxt   = PH_CODE;
          stopped_nxt = 1'b0;
          skip_nxt    = '0;
          off_nxt     = '0;
          case (e_area)
            AREA_OPT: area_nxt = AREA_FILE;
            default:  area_nxt = AREA_NAME;
          endcase
        end else begin
          off_nxt = off_inc[OFF_W-1:0];
        end
      end
    end
  end

  // Result fields.
  always_comb begin
    res.status        = ST_NOT_FOUND;
    res.area          = AREA_OPT;
    res.value_offset  = '0;
    res.value_length  = '0;
    res.overload_seen = ovl_upd;
    if (cookie_bad) begin
      res.status = ST_NO_COOKIE;
    end else if (found) begin
      res.status       = ST_FOUND;
      res.area         = e_area;
      res.value_offset = off_inc[OFF_W-1:0];
      res.value_length = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      area_r    <= AREA_OPT;
      off_r     <= '0;
      skip_r    <= '0;
      code_r    <= '0;
      ovl_r     <= '0;
      stopped_r <= 1'b0;
      done_r    <= 1'b1;
      held_r    <= OPTIONS_LENGTH_RESET;
    end else if (item_take) begin
      phase_r   <= phase_nxt;
      area_r    <= area_nxt;
      off_r     <= off_nxt;
      skip_r    <= skip_nxt;
      code_r    <= code_nxt;
      ovl_r     <= ovl_nxt;
      stopped_r <= stopped_nxt;
      done_r    <= done_nxt;
      held_r    <= held_nxt;
    end
  end

  `DOTS_ASSERT_NEXT(a_done_after_result, res_vld, done_r && (phase_r == PH_IDLE), "scan not closed after result")
  `DOTS_ASSERT_IMPLIES(a_scan_has_phase, !done_r, phase_r != PH_IDLE, "active scan without a phase")
  `DOTS_ASSERT_IMPLIES(a_no_cookie_clean, res_vld && (res.status == ST_NO_COOKIE), (res.overload_seen == 2'b00) && (res.area == AREA_OPT), "missing cookie result carries data")
  `DOTS_ASSERT_IMPLIES(a_file_offset_range, !done_r && (area_r == AREA_FILE), {1'b0, off_r} < FILE_AREA_BYTES, "file area offset out of range")
endmodule

### rtl/dots_out_stage.sv
// ---------------------------------------------------------------------------
// DHCP option scanner result register
// Holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module dots_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  dots_pkg::result_t res,
  output logic              out_free,
  dots_result_if.source     out_bus
);
  import dots_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_bus.ready;
  assign valid_nxt = res_vld || (valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_bus.valid         = valid_r;
  assign out_bus.status        = res_r.status;
  assign out_bus.area          = res_r.area;
  assign out_bus.value_offset  = res_r.value_offset;
  assign out_bus.value_length  = res_r.value_length;
  assign out_bus.overload_seen = res_r.overload_seen;
endmodule

### rtl/dhcp_option_tlv_scanner_core.sv
// ---------------------------------------------------------------------------
// DHCP option TLV scanner core
// Looks up one option code in a streamed DHCP packet, honoring overload.
// ---------------------------------------------------------------------------
// Feed the options field (cookie included), then the 128-byte file area,
// then the 64-byte server-name area, one byte per word, with packet_start
// set on the first options byte. The core takes one byte every cycle and
// gives at most one result word per packet, exactly one unless a new packet
// start cuts the scan short. The byte that decides a result is held in the
// input register while the combinational parse logic decides, and the result
// register loads when the parser takes that byte. The parse state update per
// byte sets the throughput of one byte per clock; input stalls only while a
// result word waits in the output register. Bytes after the result and bytes
// before the first packet start produce nothing. Write the search code and
// options length only while no packet is in flight.
module dhcp_option_tlv_scanner_core (
  input  logic          clk,
  input  logic          rst_n,
  dots_byte_if.sink     in_bus,
  dots_result_if.source out_bus,
  dots_cfg_if.sink      cfg_bus
);
  import dots_pkg::*;

  cfg_t    cfg;
  logic    item_vld;
  item_t   item;
  logic    item_take;
  logic    res_vld;
  result_t res;
  logic    out_free;

  dots_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  dots_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .item_take (item_take),
    .item_vld  (item_vld),
    .item      (item)
  );

  dots_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (item_vld),
    .item      (item),
    .out_free  (out_free),
    .item_take (item_take),
    .res_vld   (res_vld),
    .res       (res)
  );

  dots_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .out_free (out_free),
    .out_bus  (out_bus)
  );
endmodule

### verif/dhcp_option_tlv_scanner_core_checker.sv
// ---------------------------------------------------------------------------
// DHCP option scanner checker
// Watches the byte, result and register write channels of the scanner. It
// keeps its own copy of the lookup state and the registers, predicts the
// lookup result of each packet and compares every result word field by field.
// ---------------------------------------------------------------------------
module dhcp_option_tlv_scanner_core_checker (
  input  logic   clk,
  input  logic   rst_n,
  dots_byte_if   byte_ch,
  dots_result_if result_ch,
  dots_cfg_if    cfg_ch,
  output int     mismatch_count,
  output int     pending_count,
  output int     scanned_count,
  output logic   scan_open
);
  import dots_pkg::*;

  localparam logic [31:0] MAGIC      = 32'h6382_5363;
  localparam int          FILE_BYTES = FILE_AREA_BYTES;
  localparam int          NAME_BYTES = NAME_AREA_BYTES;

  logic [BYTE_W-1:0]    search_reg;
  logic [OPT_LEN_W-1:0] optlen_reg;

  phase_t            phase_q;
  int                pos_q;
  int                held_len;
  logic [BYTE_W-1:0] skip_q;
  logic [BYTE_W-1:0] code_q;
  logic [OVL_W-1:0]  ovl_q;
  logic              stopped_q;
  logic              done_q;

  result_t expected_lookups[$];
  result_t want;
  int      err_total;
  int      scanned_total;

  task automatic flag_mismatch(input string what);
    $display("scanner check: %s", what);
    err_total++;
  endtask

  function automatic void post_lookup(input status_t st, input area_t ar, input int off,
                                      input logic [BYTE_W-1:0] len);
    result_t r;
    r.status        = st;
    r.area          = ar;
    r.value_offset  = OFF_W'(off);
    r.value_length  = len;
    r.overload_seen = ovl_q;
    expected_lookups.push_back(r);
    done_q  = 1'b1;
    phase_q = PH_IDLE;
  endfunction

  function automatic bit area_scanned(input int a);
    if (a == 0) return 1'b1;
    if (a == 1) return ovl_q[0];
    return ovl_q[1];
  endfunction

  function automatic bit later_scanned(input int a);
    if (a == 0) return ovl_q != 2'b00;
    if (a == 1) return ovl_q[1];
    return 1'b0;
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic start);
    int a;
    int off;
    int sz;
    bit last_b;
    if (start) begin
      held_len = optlen_reg;
      if (held_len < MIN_OPTIONS_BYTES) held_len = MIN_OPTIONS_BYTES;
      if (held_len > MAX_OPTIONS_BYTES) held_len = MAX_OPTIONS_BYTES;
      phase_q   = PH_COOKIE;
      pos_q     = 0;
      skip_q    = '0;
      code_q    = '0;
      ovl_q     = '0;
      stopped_q = 1'b0;
      done_q    = 1'b0;
    end
    if (done_q) return;
    scanned_total++;

    if (pos_q < held_len) begin
      a   = 0;
      off = pos_q;
      sz  = held_len;
    end else if (pos_q - held_len < FILE_BYTES) begin
      a   = 1;
      off = pos_q - held_len;
      sz  = FILE_BYTES;
    end else begin
      a   = 2;
      off = pos_q - held_len - FILE_BYTES;
      sz  = NAME_BYTES;
      if (off >= sz) off = sz - 1;
    end

    if (!stopped_q && area_scanned(a)) begin
      case (phase_q)
        PH_COOKIE: begin
          if (b != MAGIC[8*(3-(off%4)) +: 8]) begin
            ovl_q = '0;
            post_lookup(ST_NO_COOKIE, AREA_OPT, 0, '0);
            return;
          end
          if (off >= 3) phase_q = PH_CODE;
        end
        PH_CODE: begin
          if (b == OPT_END) stopped_q = 1'b1;
          else if (b == OPT_PAD) ;
          else if (off + 1 >= sz) stopped_q = 1'b1;
          else begin
            code_q  = b;
            phase_q = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          // A length running past the end of the area stops that area.
          if (int'(b) > sz - off - 1) stopped_q = 1'b1;
          else if (code_q == search_reg) begin
            post_lookup(ST_FOUND, area_t'(a), off + 1, b);
            return;
          end else begin
            skip_q = b;
            if (b == 8'd0) phase_q = PH_CODE;
            else if (code_q == OPT_OVERLOAD && a == 0) phase_q = PH_OVERLOAD;
            else phase_q = PH_VALUE;
          end
        end
        PH_OVERLOAD: begin
          ovl_q   = b[OVL_W-1:0];
          skip_q  = skip_q - 8'd1;
          phase_q = (skip_q != 8'd0) ? PH_VALUE : PH_CODE;
        end
        PH_VALUE: begin
          skip_q = skip_q - 8'd1;
          if (skip_q == 8'd0) phase_q = PH_CODE;
        end
        default: phase_q = PH_CODE;
      endcase
    end

    last_b = (off + 1 >= sz);
    if ((stopped_q || last_b) && !later_scanned(a)) begin
      post_lookup(ST_NOT_FOUND, AREA_OPT, 0, '0);
      return;
    end
    if (last_b) begin
      phase_q   = PH_CODE;
      stopped_q = 1'b0;
      skip_q    = '0;
    end
    pos_q++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      search_reg    = SEARCH_CODE_RESET;
      optlen_reg    = OPTIONS_LENGTH_RESET;
      held_len      = OPTIONS_LENGTH_RESET;
      phase_q       = PH_IDLE;
      pos_q         = 0;
      skip_q        = '0;
      code_q        = '0;
      ovl_q         = '0;
      stopped_q     = 1'b0;
      done_q        = 1'b1;
      err_total     = 0;
      scanned_total = 0;
      expected_lookups.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.reg_index))
          CFG_SEARCH_CODE:    search_reg = cfg_ch.wdata[BYTE_W-1:0];
          CFG_OPTIONS_LENGTH: optlen_reg = cfg_ch.wdata[OPT_LEN_W-1:0];
          default: ;
        endcase
      end

      // A result word can never come from a byte taken at the same edge.
      if (result_ch.valid && result_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          flag_mismatch($sformatf("result word with no lookup pending, status %0d",
                                  result_ch.status));
        end else begin
          want = expected_lookups.pop_front();
          if (result_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", result_ch.status, want.status));
          if (result_ch.area !== want.area)
            flag_mismatch($sformatf("area %0d, want %0d", result_ch.area, want.area));
          if (result_ch.value_offset !== want.value_offset)
            flag_mismatch($sformatf("value_offset %0d, want %0d", result_ch.value_offset,
                                    want.value_offset));
          if (result_ch.value_length !== want.value_length)
            flag_mismatch($sformatf("value_length %0d, want %0d", result_ch.value_length,
                                    want.value_length));
          if (result_ch.overload_seen !== want.overload_seen)
            flag_mismatch($sformatf("overload_seen %0d, want %0d", result_ch.overload_seen,
                                    want.overload_seen));
        end
      end

      if (byte_ch.valid && byte_ch.ready) scan_byte(byte_ch.data_byte, byte_ch.packet_start);
    end

    mismatch_count <= err_total;
    pending_count  <= expected_lookups.size();
    scanned_count  <= scanned_total;
    scan_open      <= !done_q;
  end

endmodule

### verif/dhcp_option_tlv_scanner_core_tb.sv
// ---------------------------------------------------------------------------
// DHCP option scanner testbench
// Streams directed and random DHCP packets through the scanner, with random
// idle cycles on both channels, a long receiver hold-off and several search
// code and options length settings. A checker beside the core predicts and
// compares every result word; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module dhcp_option_tlv_scanner_core_tb;
  import dots_pkg::*;

  localparam int SCAN_ITEMS  = 290;
  localparam int QUIET_AFTER = 230;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  dots_byte_if   in_bus();
  dots_result_if out_bus();
  dots_cfg_if    cfg_bus();

  int   lookup_errors;
  int   lookups_pending;
  int   bytes_scanned;
  logic scan_open;

  int                hold_req;
  bit                quiet;
  int                opt_bytes;
  logic [BYTE_W-1:0] search_now;
  logic [BYTE_W-1:0] pkt[$];
  int                round_n;
  int                scan_base;
  int                n;

  dhcp_option_tlv_scanner_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  dhcp_option_tlv_scanner_core_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_ch        (in_bus),
    .result_ch      (out_bus),
    .cfg_ch         (cfg_bus),
    .mismatch_count (lookup_errors),
    .pending_count  (lookups_pending),
    .scanned_count  (bytes_scanned),
    .scan_open      (scan_open)
  );

  initial begin
    #5_000_000;
    $display("dhcp_option_tlv_scanner_core_tb NOT OK");
    $finish;
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int served;
    int span;
    served = 0;
    forever begin
      if (hold_req != served) begin
        served++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        span = $urandom_range(1, 6);
        repeat (span) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic start);
    int span;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      span = $urandom_range(1, 6);
      repeat (span) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.packet_start <= start;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // The scan state seen here lags by one word, so the first two words always go.
  task automatic send_packet(ref logic [BYTE_W-1:0] q[$], input int cut);
    int k;
    for (k = 0; k < q.size() && k < cut; k++) begin
      if (k >= 2 && !scan_open) break;
      put_byte(q[k], k == 0);
    end
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
    // Bytes that make no result may still sit in the core's pipeline.
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] sc, input logic [OPT_LEN_W-1:0] ol);
    settle();
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= CFG_SEARCH_CODE;
    cfg_bus.wdata     <= CFG_DATA_W'(sc);
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.reg_index <= CFG_OPTIONS_LENGTH;
    cfg_bus.wdata     <= ol;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    opt_bytes  = ol;
    if (opt_bytes < MIN_OPTIONS_BYTES) opt_bytes = MIN_OPTIONS_BYTES;
    if (opt_bytes > MAX_OPTIONS_BYTES) opt_bytes = MAX_OPTIONS_BYTES;
    search_now = sc;
  endtask

  // Fills one area with pads, end codes and code/length/value entries, cut to the area size.
  function automatic void add_area(ref logic [BYTE_W-1:0] q[$], input int size,
                                   input bit plant);
    int base;
    int room;
    int r;
    int len;
    int i;
    logic [BYTE_W-1:0] c;
    base = q.size();
    while (q.size() - base < size) begin
      room = size - (q.size() - base);
      r    = $urandom_range(0, 99);
      if (r < 10) q.push_back(OPT_PAD);
      else if (r < 14) q.push_back(OPT_END);
      else begin
        if (plant && r < 30) c = search_now;
        else if (r < 42) c = OPT_OVERLOAD;
        else c = 8'($urandom_range(1, 254));
        len = (c == OPT_OVERLOAD) ? $urandom_range(0, 3) : $urandom_range(0, 8);
        // Now and then a length right at the end of the area, fitting or not.
        if ($urandom_range(0, 19) == 0) len = room - 2 + $urandom_range(0, 3);
        if (len < 0) len = 0;
        if (len > 255) len = 255;
        q.push_back(c);
        q.push_back(8'(len));
        for (i = 0; i < len; i++) q.push_back(8'($urandom));
      end
    end
    while (q.size() - base > size) void'(q.pop_back());
  endfunction

  function automatic void build_packet(ref logic [BYTE_W-1:0] q[$], input bit plant);
    int body;
    int k;
    q = '{8'd99, 8'd130, 8'd83, 8'd99};
    if ($urandom_range(0, 11) == 0) begin
      k    = $urandom_range(0, 3);
      q[k] = q[k] ^ 8'($urandom_range(1, 255));
    end
    body = opt_bytes - 4;
    if (body >= 3 && $urandom_range(0, 9) < 4) begin
      q.push_back(OPT_OVERLOAD);
      q.push_back(8'd1);
      q.push_back(8'($urandom_range(0, 3)));
      body -= 3;
    end
    add_area(q, body, plant);
    add_area(q, FILE_AREA_BYTES, plant);
    add_area(q, NAME_AREA_BYTES, plant);
  endfunction

  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.data_byte    <= '0;
    in_bus.packet_start <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.reg_index   <= CFG_SEARCH_CODE;
    cfg_bus.wdata       <= '0;
    hold_req            <= 0;
    opt_bytes           = OPTIONS_LENGTH_RESET;
    search_now          = SEARCH_CODE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray words before any packet start are dropped.
    put_byte(8'hA5, 1'b0);
    put_byte(8'h63, 1'b0);

    // Reset settings: two bad cookies, found at once, pads then empty value, end at once.
    pkt = '{8'd99, 8'd131, 8'd83, 8'd99, 8'd1, 8'd0};
    send_packet(pkt, pkt.size());
    pkt = '{8'd99, 8'd130, 8'd83, 8'd98, 8'd1};
    send_packet(pkt, pkt.size());
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd1, 8'd4, 8'd10, 8'd20, 8'd30, 8'd40};
    send_packet(pkt, pkt.size());
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd0, 8'd0, 8'd3, 8'd2, 8'd7, 8'd7, 8'd1, 8'd0};
    send_packet(pkt, pkt.size());
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd255, 8'd1};
    send_packet(pkt, pkt.size());

    // Short options field: overload into the file area, then into the name area.
    set_config(8'd1, 11'd12);
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd52, 8'd1, 8'd3, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
            8'd1, 8'd2, 8'd5, 8'd6, 8'd0, 8'd0};
    send_packet(pkt, pkt.size());
    // Zero-length overload option first: the bits stay as they were.
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd52, 8'd0, 8'd52, 8'd2, 8'd2, 8'd9, 8'd255, 8'd0};
    repeat (128) pkt.push_back(8'd1);
    pkt.push_back(8'd0);
    pkt.push_back(8'd1);
    pkt.push_back(8'd3);
    repeat (3) pkt.push_back(8'd4);
    send_packet(pkt, pkt.size());
    // Length past the end of the area, then a code on the last byte.
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd7, 8'd200, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
    send_packet(pkt, pkt.size());
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9};
    send_packet(pkt, pkt.size());

    // Looking up the overload option itself.
    set_config(OPT_OVERLOAD, 11'd12);
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd52, 8'd1, 8'd3, 8'd255};
    send_packet(pkt, pkt.size());

    // Saturated options length with an early hit.
    set_config(8'd9, 11'd2047);
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd0, 8'd9, 8'd3, 8'd1, 8'd2, 8'd3};
    send_packet(pkt, pkt.size());

    // Options length below the cookie: the option list is empty.
    set_config(OPT_PAD, 11'd0);
    pkt = '{8'd99, 8'd130, 8'd83, 8'd99, 8'd1, 8'd2};
    send_packet(pkt, pkt.size());

    // Receiver holds off while bad-cookie packets keep coming, so the core backs up.
    hold_req <= hold_req + 1;
    for (n = 0; n < 5; n++) begin
      pkt = '{8'($urandom_range(0, 98)), 8'd7};
      send_packet(pkt, pkt.size());
    end
    settle();

    scan_base = bytes_scanned;
    round_n   = 0;
    while (bytes_scanned - scan_base < SCAN_ITEMS) begin
      case (round_n % 7)
        0:       set_config(8'($urandom_range(1, 254)), 11'($urandom_range(4, 48)));
        1:       set_config(OPT_OVERLOAD, 11'($urandom_range(8, 40)));
        2:       set_config(OPT_PAD, 11'($urandom_range(0, 3)));
        3:       set_config(OPT_END, 11'($urandom_range(16, 64)));
        4:       set_config(8'($urandom_range(0, 255)), 11'd2047);
        5:       set_config(8'($urandom_range(1, 254)), 11'($urandom_range(5, 12)));
        default: set_config(8'($urandom_range(1, 254)), 11'($urandom_range(100, 400)));
      endcase
      for (n = 0; n < 2; n++) begin
        if (bytes_scanned - scan_base >= SCAN_ITEMS) break;
        if (bytes_scanned - scan_base >= QUIET_AFTER) quiet <= 1'b1;
        build_packet(pkt, 1'($urandom_range(0, 1)));
        // Some packets are cut short and the next start aborts the scan.
        send_packet(pkt, ($urandom_range(0, 9) == 0) ? $urandom_range(1, pkt.size())
                                                     : pkt.size());
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
        end
      end
      round_n++;
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < 5000 && lookups_pending != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lookups_pending != 0) $display("lookups still outstanding: %0d", lookups_pending);
    if (lookup_errors == 0 && lookups_pending == 0) begin
      $display("dhcp_option_tlv_scanner_core_tb OK");
    end else begin
      $display("dhcp_option_tlv_scanner_core_tb NOT OK");
    end
    $finish;
  end

endmodule
